// ===== rtl/teq_pkg.sv =====
package teq_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned KIND_BITS  = 3;
  localparam int unsigned CNT_BITS   = $clog2(DEPTH + 1);
  localparam int unsigned TOTAL_BITS = 32;

  localparam int unsigned IN_FIELDS_W  = KIND_BITS + TIME_BITS;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = KIND_BITS + TIME_BITS + CNT_BITS + TOTAL_BITS;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W   = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic [TIME_BITS-1:0] ev_time;
    logic [KIND_BITS-1:0] kind;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } cell_ctrl_t;

  typedef struct packed {
    logic                  pop_valid;
    logic [KIND_BITS-1:0]  popped_kind;
    logic [TIME_BITS-1:0]  popped_time;
    logic                  was_empty;
    logic                  insert_rejected;
    logic [CNT_BITS-1:0]   entries_held;
    logic [TOTAL_BITS-1:0] inserts_total;
  } result_t;

endpackage

// ===== rtl/teq_cell.sv =====
module teq_cell
  import teq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  logic       prev_le_i,
  input  entry_t     prev_i,
  input  entry_t     next_i,
  output logic       le_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // This cell keeps its entry on insert when that entry is stored and not later than the new one.
  assign le_o    = occ_i && (entry_q.ev_time <= ctrl_i.ent.ev_time);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !le_o) begin
      entry_d = prev_le_i ? ctrl_i.ent : prev_i;
    end else if (ctrl_i.pop) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/time_ordered_event_queue.sv =====
// Each result is registered and offered on the output in the cycle after its input transfer.
// Throughput: one operation per cycle while the output is drained; every cell compares and shifts in the same cycle.
// A new input is taken while the previous result waits, if the output register is drained.
// Reset clears the occupancy, the insert total and the output valid flag.
// The stored entries are not cleared; only occupied cells are ever read.
module time_ordered_event_queue
  import teq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // event_kind, event_time, zero padding
  input  logic                  s_axis_tuser,  // op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // popped_kind, popped_time, entries_held,
                                               // inserts_total, zero padding
  output logic [OUT_USER_W-1:0] m_axis_tuser   // pop_valid, was_empty, insert_rejected
);

  logic                  in_acc;
  logic                  op;
  logic                  full, empty;
  logic                  ins_ok, pop_ok;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [TOTAL_BITS-1:0] total_q, total_d;
  logic                  out_valid_q, out_valid_d;
  result_t               res_q, res_d;
  cell_ctrl_t            ctrl;
  entry_t                new_ent;
  entry_t                cell_ent [DEPTH];
  logic [DEPTH-1:0]      le;
  logic [DEPTH-1:0]      occ;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op            = s_axis_tuser;

  assign new_ent.kind    = s_axis_tdata[KIND_BITS-1:0];
  assign new_ent.ev_time = s_axis_tdata[KIND_BITS +: TIME_BITS];

  assign full   = (count_q == CNT_BITS'(DEPTH));
  assign empty  = (count_q == '0);
  assign ins_ok = in_acc && (op == OP_INSERT) && !full;
  assign pop_ok = in_acc && (op == OP_POP) && !empty;

  assign ctrl.ins = ins_ok;
  assign ctrl.pop = pop_ok;
  assign ctrl.ent = new_ent;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_ent, next_ent;
    logic   prev_le;

    assign occ[i] = (count_q > CNT_BITS'(i));

    if (i == 0) begin : g_head
      assign prev_ent = new_ent;
      assign prev_le  = 1'b1;
    end else begin : g_body
      assign prev_ent = cell_ent[i-1];
      assign prev_le  = le[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_ent = cell_ent[i];
    end else begin : g_inner
      assign next_ent = cell_ent[i+1];
    end

    teq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (occ[i]),
      .prev_le_i (prev_le),
      .prev_i    (prev_ent),
      .next_i    (next_ent),
      .le_o      (le[i]),
      .entry_o   (cell_ent[i])
    );
  end

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    if (ins_ok) begin
      count_d = count_q + CNT_BITS'(1);
      if (total_q != '1) begin
        total_d = total_q + TOTAL_BITS'(1);
      end
    end else if (pop_ok) begin
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_comb begin
    res_d.pop_valid       = pop_ok;
    res_d.popped_kind     = pop_ok ? cell_ent[0].kind : '0;
    res_d.popped_time     = pop_ok ? cell_ent[0].ev_time : '0;
    res_d.was_empty       = (op == OP_POP) && empty;
    res_d.insert_rejected = (op == OP_INSERT) && full;
    res_d.entries_held    = count_d;
    res_d.inserts_total   = total_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), res_q.inserts_total,
                          res_q.entries_held, res_q.popped_time, res_q.popped_kind};
  assign m_axis_tuser  = {res_q.insert_rejected, res_q.was_empty, res_q.pop_valid};

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("occupancy exceeds the queue depth");

  a_pop_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == OP_POP) && !empty) |=> (m_axis_tvalid && m_axis_tuser[0]
      && (count_q == $past(count_q) - CNT_BITS'(1))))
    else $error("a pop from a non-empty queue did not deliver its entry");

  a_full_reject : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == OP_INSERT) && full) |=> (m_axis_tuser[2] && $stable(count_q)
      && $stable(total_q)))
    else $error("an insert into a full queue changed the state");

  a_idle_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> ($stable(count_q) && $stable(total_q)))
    else $error("queue state changed without an input transfer");

  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

endmodule
